@@ rtl/mpf_pkg.sv @@
// shared constants for the monochrome page frame buffer
`default_nettype none

package mpf_pkg;

  // default geometry
  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 8;

  // operation codes on the mode field
  localparam logic [2:0] MODE_WRITE   = 3'd0;
  localparam logic [2:0] MODE_READ    = 3'd1;
  localparam logic [2:0] MODE_CLEAR   = 3'd2;
  localparam logic [2:0] MODE_REFRESH = 3'd3;
  localparam logic [2:0] MODE_SLEEP   = 3'd4;

  // panel command bytes
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_SLEEP  = 8'hAE;

  // command bytes in front of each page's data
  localparam int PAGE_HEADER = 3;

endpackage

`default_nettype wire

@@ rtl/mono_page_framebuffer.sv @@
// monochrome page frame buffer top level: pixel access, clear and panel refresh stream
//
//  channel   ports                                          transfer
//  command   start, busy, mode, col, row, paint_black       start & !busy at clk edge
//  result    result_strobe, pixel_black, link_byte,         result_strobe, one cycle
//            is_data, frame_end, backlight_on
//
// Every item except clear reads the store at the accepting edge and is written
// back or answered in the cycle after, so busy is high for one cycle.
// A clear holds busy while a sweep zeroes all PAGES*COLUMNS bytes (1024 by
// default) of the store one byte a cycle; the same sweep runs right after reset.
// The result appears in the same cycle that busy drops; the receiver cannot stall it.
`default_nettype none

module mono_page_framebuffer #(
  parameter int COLUMNS = mpf_pkg::DEF_COLUMNS,
  parameter int PAGES   = mpf_pkg::DEF_PAGES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] mode,
  input  wire logic [6:0] col,
  input  wire logic [5:0] row,
  input  wire logic       paint_black,
  output logic            result_strobe,
  output logic            pixel_black,
  output logic      [7:0] link_byte,
  output logic            is_data,
  output logic            frame_end,
  output logic            backlight_on
);

  import mpf_pkg::*;

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int OW    = $clog2(COLUMNS + PAGE_HEADER);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_CLEAR  = 2'd2;

  logic [1:0]    state;
  logic [AW-1:0] sweep;
  logic          accept;

  // refresh stream position as page and offset within the page
  logic [PW-1:0] ref_page;
  logic [OW-1:0] ref_off;
  logic          backlight;

  // captured item
  logic [2:0]    op_mode;
  logic [AW-1:0] op_addr;
  logic [7:0]    op_mask;
  logic          op_paint;
  logic          op_hit;
  logic [7:0]    op_byte;
  logic          op_data;
  logic          op_end;

  logic          pix_hit;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] ref_addr;
  logic [CW-1:0] ref_col;
  logic          ref_last_off;
  logic          ref_last_page;
  logic [7:0]    ref_byte;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // pixel address decode
  assign pix_hit  = (9'(col) < 9'(COLUMNS)) && (5'(row[5:3]) < 5'(PAGES));
  assign pix_addr = AW'(32'(row[5:3]) * 32'(COLUMNS) + 32'(col));

  // refresh byte decode
  assign ref_col       = CW'(ref_off - OW'(PAGE_HEADER));
  assign ref_addr      = AW'(32'(ref_page) * 32'(COLUMNS) + 32'(ref_col));
  assign ref_last_off  = (ref_off == OW'(COLUMNS + PAGE_HEADER - 1));
  assign ref_last_page = (ref_page == PW'(PAGES - 1));

  always_comb begin
    priority if (ref_off == OW'(0)) begin
      ref_byte = CMD_COL_LO;
    end else if (ref_off == OW'(1)) begin
      ref_byte = CMD_COL_HI;
    end else begin
      ref_byte = CMD_PAGE | 8'(ref_page);
    end
  end

  // frame store
  mpf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr ((mode == MODE_REFRESH) ? ref_addr : pix_addr),
    .rd_data (rd_data)
  );

  // write port: pixel write-back or clearing sweep
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = op_addr;
    wr_data = op_paint ? (rd_data | op_mask) : (rd_data & ~op_mask);
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = sweep;
      wr_data = 8'h00;
    end else if (state == ST_ACCESS && op_mode == MODE_WRITE && op_hit) begin
      wr_en = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      ref_page  <= '0;
      ref_off   <= '0;
      backlight <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (mode == MODE_CLEAR) begin
              state <= ST_CLEAR;
              sweep <= '0;
            end else begin
              state <= ST_ACCESS;
            end
            if (mode == MODE_REFRESH) begin
              backlight <= 1'b1;
              if (ref_last_off) begin
                ref_off  <= '0;
                ref_page <= ref_last_page ? '0 : ref_page + PW'(1);
              end else begin
                ref_off <= ref_off + OW'(1);
              end
            end else if (mode == MODE_SLEEP) begin
              backlight <= 1'b0;
            end
          end
        end
        ST_ACCESS: begin
          state <= ST_IDLE;
        end
        ST_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item capture on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= mode;
      op_addr  <= pix_addr;
      op_mask  <= 8'(1) << row[2:0];
      op_paint <= paint_black;
      op_hit   <= pix_hit;
      op_byte  <= ref_byte;
      op_data  <= (ref_off >= OW'(PAGE_HEADER));
      op_end   <= ref_last_off && ref_last_page;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == ST_ACCESS) &&
                       (op_mode == MODE_READ || op_mode == MODE_REFRESH ||
                        op_mode == MODE_SLEEP);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_ACCESS) begin
      backlight_on <= backlight;
      pixel_black  <= 1'b0;
      link_byte    <= 8'h00;
      is_data      <= 1'b0;
      frame_end    <= 1'b0;
      if (op_mode == MODE_READ) begin
        pixel_black <= op_hit && ((rd_data & op_mask) != 8'h00);
      end else if (op_mode == MODE_REFRESH) begin
        link_byte <= op_data ? rd_data : op_byte;
        is_data   <= op_data;
        frame_end <= op_end;
      end else if (op_mode == MODE_SLEEP) begin
        link_byte <= CMD_SLEEP;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mpf_store.sv @@
// frame store memory: one write port, one registered read port
`default_nettype none

module mpf_store #(
  parameter int DEPTH = mpf_pkg::DEF_COLUMNS * mpf_pkg::DEF_PAGES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
